// ----- src/q4dot_pkg.sv -----
// ----------------------------------------------------------------------------
// q4dot_pkg: shared types and fp32 helpers for the quantized row dot product.
// Holds the fp16 widening used at the input and the fp32 multiply and add
// used by the lanes and the accumulator. All operations round to nearest even.
// ----------------------------------------------------------------------------
`default_nettype none

package q4dot_pkg;

  localparam logic [31:0] F32_EXP_MASK = 32'h7F80_0000;
  localparam logic [31:0] F32_QNAN     = 32'h7FC0_0000;
  localparam logic [3:0]  NIBBLE_MASK  = 4'hF;

  typedef struct packed {
    logic        valid;
    logic        last;
  } q4dot_ctl_t;

  function automatic logic [31:0] half_to_f32(input logic [15:0] h);
    logic        s;
    logic [4:0]  e;
    logic [9:0]  m;
    logic [7:0]  e32;
    logic [10:0] mm;
    logic [31:0] r;
    s = h[15];
    e = h[14:10];
    m = h[9:0];
    r = {s, 31'd0};
    if (e == 5'd0) begin
      if (m != 10'd0) begin
        mm  = {1'b0, m};
        e32 = 8'd113;
        for (int i = 0; i < 10; i++) begin
          if (!mm[10]) begin
            mm  = mm << 1;
            e32 = e32 - 8'd1;
          end
        end
        r = {s, e32, mm[9:0], 13'd0};
      end
    end else if (e == 5'h1F) begin
      r = (m == 10'd0) ? {s, F32_EXP_MASK[30:0]} : F32_QNAN;
    end else begin
      r = {s, 8'(e) + 8'd112, m, 13'd0};
    end
    return r;
  endfunction

  function automatic logic [31:0] u4_to_f32(input logic [3:0] q);
    logic [7:0]  e;
    logic [3:0]  mm;
    logic [31:0] r;
    r  = 32'd0;
    mm = q;
    e  = 8'd130;
    if (q != 4'd0) begin
      for (int i = 0; i < 3; i++) begin
        if (!mm[3]) begin
          mm = mm << 1;
          e  = e - 8'd1;
        end
      end
      r = {1'b0, e, mm[2:0], 20'd0};
    end
    return r;
  endfunction

  // Rounds a positive significand with explicit leading one at bit 26 and
  // sticky at bit 0, biased exponent ex (may be <= 0), into fp32 bits.
  function automatic logic [31:0] f32_pack(input logic s, input logic signed [11:0] ex,
                                           input logic [26:0] sig);
    logic [26:0]         t;
    logic                st;
    logic signed [11:0]  e;
    logic [24:0]         rm;
    logic                rup;
    logic [31:0]         r;
    t = sig;
    e = ex;
    if (e < 12'sd1) begin
      st = 1'b0;
      for (int i = 0; i < 27; i++) begin
        if (e < 12'sd1) begin
          st = st | t[0];
          t  = {1'b0, t[26:1]};
          t[0] = t[0] | st;
          e  = e + 12'sd1;
        end
      end
      e = 12'sd0;
    end
    rup = t[2] & (t[1] | t[0] | t[3]);
    rm  = {1'b0, t[26:3]} + 25'(rup);
    if (rm[24]) begin
      rm = rm >> 1;
      e  = e + 12'sd1;
    end
    if (e == 12'sd0 && rm[23]) e = 12'sd1;
    if (e >= 12'sd255) r = {s, F32_EXP_MASK[30:0]};
    else r = {s, e[7:0], rm[22:0]};
    return r;
  endfunction

  function automatic logic [31:0] f32_mul(input logic [31:0] a, input logic [31:0] b);
    logic               s;
    logic [7:0]         ea, eb;
    logic [23:0]        ma, mb;
    logic [47:0]        p;
    logic signed [11:0] e;
    logic [26:0]        sig;
    logic [31:0]        r;
    s  = a[31] ^ b[31];
    ea = a[30:23];
    eb = b[30:23];
    ma = {ea != 8'd0, a[22:0]};
    mb = {eb != 8'd0, b[22:0]};
    if ((ea == 8'hFF && a[22:0] != 0) || (eb == 8'hFF && b[22:0] != 0)) begin
      r = F32_QNAN;
    end else if (ea == 8'hFF || eb == 8'hFF) begin
      if ((ea == 8'd0 && ma == 0) || (eb == 8'd0 && mb == 0)) r = 32'hFFC0_0000;
      else r = {s, F32_EXP_MASK[30:0]};
    end else if (ma == 24'd0 || mb == 24'd0) begin
      r = {s, 31'd0};
    end else begin
      e = 12'(ea + (ea == 8'd0)) + 12'(eb + (eb == 8'd0)) - 12'sd127;
      p = ma * mb;
      for (int i = 0; i < 48; i++) begin
        if (!p[47] && !p[46]) begin
          p = p << 1;
          e = e - 12'sd1;
        end
      end
      if (p[47]) begin
        sig = {p[47:22], |p[21:0]};
        e   = e + 12'sd1;
      end else begin
        sig = {p[46:21], |p[20:0]};
      end
      r = f32_pack(s, e, sig);
    end
    return r;
  endfunction

  function automatic logic [31:0] f32_add(input logic [31:0] a, input logic [31:0] b);
    logic [31:0]        x, y, r;
    logic [7:0]         ex, ey;
    logic [26:0]        mx, my;
    logic [27:0]        sm;
    logic [8:0]         d;
    logic               st;
    logic signed [11:0] e;
    logic               sub;
    if ((a[30:23] == 8'hFF && a[22:0] != 0) || (b[30:23] == 8'hFF && b[22:0] != 0)) begin
      r = F32_QNAN;
    end else if (a[30:23] == 8'hFF || b[30:23] == 8'hFF) begin
      if (a[30:23] == 8'hFF && b[30:23] == 8'hFF && a[31] != b[31]) r = 32'hFFC0_0000;
      else r = (a[30:23] == 8'hFF) ? a : b;
    end else begin
      if (a[30:0] >= b[30:0]) begin
        x = a; y = b;
      end else begin
        x = b; y = a;
      end
      ex  = x[30:23] + 8'(x[30:23] == 8'd0);
      ey  = y[30:23] + 8'(y[30:23] == 8'd0);
      mx  = {x[30:23] != 8'd0, x[22:0], 3'd0};
      my  = {y[30:23] != 8'd0, y[22:0], 3'd0};
      d   = 9'(ex) - 9'(ey);
      st  = 1'b0;
      for (int i = 0; i < 27; i++) begin
        if (9'(i) < d) begin
          st = st | my[0];
          my = {1'b0, my[26:1]};
        end
      end
      if (d > 9'd26) my = 27'd0;
      my[0] = my[0] | st | ((d > 9'd26) && (y[30:0] != 0));
      sub = x[31] ^ y[31];
      sm  = sub ? ({1'b0, mx} - {1'b0, my}) : ({1'b0, mx} + {1'b0, my});
      e   = 12'(ex);
      if (sm == 28'd0) begin
        r = {(a[31] & b[31]), 31'd0};
      end else begin
        if (sm[27]) begin
          sm = {1'b0, sm[27:2], sm[1] | sm[0]};
          e  = e + 12'sd1;
        end
        for (int i = 0; i < 27; i++) begin
          if (!sm[26] && e > 12'sd1) begin
            sm = sm << 1;
            e  = e - 12'sd1;
          end
        end
        if (!sm[26]) begin
          sm = sm << 1;
          e  = 12'sd0;
        end
        r = f32_pack(x[31], e, sm[26:0]);
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- src/q4dot_lane.sv -----
// ----------------------------------------------------------------------------
// q4dot_lane: one nibble term.
// Computes act * (q * d - dmin) over three registered stages.
// ----------------------------------------------------------------------------
`default_nettype none

module q4dot_lane
  import q4dot_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [3:0]  nib,
  input  wire logic [31:0] d_f,
  input  wire logic [31:0] dmin_f,
  input  wire logic [31:0] act,
  output logic      [31:0] term
);

  logic [31:0] qd_r, w_r, act1_r, act2_r, term_r;
  logic [31:0] act_z;

  assign act_z = ((act & F32_EXP_MASK) == F32_EXP_MASK) ? 32'd0 : act;

  always_ff @(posedge clk) begin
    if (en) begin
      qd_r   <= f32_mul(u4_to_f32(nib & NIBBLE_MASK), d_f);
      act1_r <= act_z;
      w_r    <= f32_add(qd_r, {~dmin_f[31], dmin_f[30:0]});
      act2_r <= act1_r;
      term_r <= f32_mul(act2_r, w_r);
    end
  end

  assign term = term_r;

endmodule

`default_nettype wire

// ----- src/q4dot_merge.sv -----
// ----------------------------------------------------------------------------
// q4dot_merge: running sum of lane terms.
// Adds the low term, then the high term, in two registered steps; clear zeroes the sum.
// ----------------------------------------------------------------------------
`default_nettype none

module q4dot_merge
  import q4dot_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        add_lo,
  input  wire logic        add_hi,
  input  wire logic        clear,
  input  wire logic [31:0] term_lo,
  input  wire logic [31:0] term_hi,
  output logic      [31:0] sum
);

  logic [31:0] sum_r, sum_nxt;

  always_comb begin
    sum_nxt = sum_r;
    if (add_lo) sum_nxt = f32_add(sum_r, term_lo);
    else if (add_hi) sum_nxt = f32_add(sum_r, term_hi);
    else if (clear) sum_nxt = 32'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= 32'd0;
    end else begin
      sum_r <= sum_nxt;
    end
  end

  assign sum = sum_r;

endmodule

`default_nettype wire

// ----- src/quant4_block_row_dot.sv -----
// ----------------------------------------------------------------------------
// quant4_block_row_dot: row dot product of 4-bit weights with fp32 activations.
// The in_ channel takes one item: a block scale and offset in fp16, a weight
// byte and the two activations for its nibbles, plus a row end flag. Two
// lanes compute the low and high nibble terms side by side in three stages;
// the accumulator then adds the low term and then the high term.
// One item is in flight at a time, from acceptance through one widening
// stage, three lane stages and two accumulator additions. in_stall stays
// high through the additions and the state after them, and longer while a
// row end result waits, so no new item is taken until the last is through.
// On a row end the sum, with Inf or NaN replaced by zero, is placed in the
// output register and the sum is cleared. A new item is taken while that
// result waits, but a following row end result waits for the output register
// to empty. Stall on out_ holds out_valid and out_row_result steady.
// Reset empties the pipeline and the output register and zeroes the sum.
// ----------------------------------------------------------------------------
`default_nettype none

module quant4_block_row_dot
  import q4dot_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [15:0] in_scale_half,
  input  wire logic [15:0] in_min_half,
  input  wire logic [7:0]  in_weight_byte,
  input  wire logic [31:0] in_act_low,
  input  wire logic [31:0] in_act_high,
  input  wire logic        in_row_end,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic      [31:0] out_row_result
);

  logic [2:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        last_r;
  logic [31:0] d_r, dmin_r, alo_r, ahi_r;
  logic [7:0]  wb_r;
  logic        ov_r, ov_nxt;
  logic [31:0] res_r;
  logic [31:0] t_lo, t_hi, sum;
  logic        acc, fin;
  q4dot_ctl_t  ctl;

  assign acc = in_valid && !in_stall;
  assign ctl = '{valid: busy_r, last: last_r};
  assign fin = ctl.valid && cnt_r == 3'd5 && ctl.last;
  assign in_stall = busy_r;

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    ov_nxt   = ov_r && out_stall;
    if (acc) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 3'd0;
    end else if (busy_r) begin
      if (cnt_r == 3'd5) begin
        if (!(ctl.last && ov_nxt)) begin
          busy_nxt = 1'b0;
          if (ctl.last) ov_nxt = 1'b1;
        end
      end else begin
        cnt_nxt = cnt_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= 3'd0;
      ov_r   <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
      ov_r   <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      d_r    <= half_to_f32(in_scale_half);
      dmin_r <= half_to_f32(in_min_half);
      wb_r   <= in_weight_byte;
      alo_r  <= in_act_low;
      ahi_r  <= in_act_high;
      last_r <= in_row_end;
    end
    if (fin && !(ov_r && out_stall)) begin
      res_r <= ((sum & F32_EXP_MASK) == F32_EXP_MASK) ? 32'd0 : sum;
    end
  end

  q4dot_lane u_lane_lo (
    .clk(clk), .en(busy_r), .nib(wb_r[3:0]), .d_f(d_r), .dmin_f(dmin_r),
    .act(alo_r), .term(t_lo)
  );

  q4dot_lane u_lane_hi (
    .clk(clk), .en(busy_r), .nib(wb_r[7:4]), .d_f(d_r), .dmin_f(dmin_r),
    .act(ahi_r), .term(t_hi)
  );

  q4dot_merge u_merge (
    .clk(clk), .rst_n(rst_n),
    .add_lo(busy_r && cnt_r == 3'd3),
    .add_hi(busy_r && cnt_r == 3'd4),
    .clear(fin && !(ov_r && out_stall)),
    .term_lo(t_lo), .term_hi(t_hi), .sum(sum)
  );

  assign out_valid      = ov_r;
  assign out_row_result = res_r;

endmodule

`default_nettype wire
